/* hdl/tftp_option_ack_parser_defines.svh */
// Assertion macros used by the parser top level.
`ifndef TFTP_OPTION_ACK_PARSER_DEFINES_SVH
`define TFTP_OPTION_ACK_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TOAP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define TOAP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tftp_oack_pkg.sv */
// Types, codes and keyword tables for the TFTP option-ack parser.
package tftp_oack_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] block_size;
    logic signed [31:0] timeout_value;
    logic signed [31:0] transfer_size;
    logic [7:0]         option_count;
    logic               end_kind;
  } out_beat_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPCODE,
    PH_NAME,
    PH_VLEAD,
    PH_VDIGITS
  } phase_t;

  typedef enum logic [1:0] {
    OPT_NONE,
    OPT_BLKSIZE,
    OPT_TIMEOUT,
    OPT_TSIZE
  } opt_t;

  localparam logic END_EMPTY_SEG = 1'b0;
  localparam logic END_LAST_BYTE = 1'b1;

  // keyword index 0..2 maps to OPT_BLKSIZE..OPT_TSIZE
  localparam int NUM_KW = 3;
  localparam logic [6:0][7:0] KW_BLKSIZE = "blksize";
  localparam logic [6:0][7:0] KW_TIMEOUT = "timeout";
  localparam logic [6:0][7:0] KW_TSIZE   = {"tsize", 16'h0000};
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd7, 3'd7, 3'd5};

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

  // lower-case keyword character at a name position (pos < 7)
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [2:0] idx;
    idx = 3'd6 - pos;
    case (k)
      2'd0:    kw_char = KW_BLKSIZE[idx];
      2'd1:    kw_char = KW_TIMEOUT[idx];
      2'd2:    kw_char = KW_TSIZE[idx];
      default: kw_char = 8'h00;
    endcase
  endfunction

endpackage

/* hdl/tftp_oack_core.sv */
// Parser state and per-byte update: one registered byte in, optional result out.
module tftp_oack_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  tftp_oack_pkg::in_beat_t beat,
  output logic                    emit,
  output tftp_oack_pkg::out_beat_t result
);
  import tftp_oack_pkg::*;

  phase_t      phase, phase_next;
  logic [2:0]  flags, flags_next;
  logic [2:0]  pos, pos_next;
  logic        seg_empty, seg_empty_next;
  logic [31:0] acc, acc_next;
  logic        neg, neg_next;
  logic        done, done_next;
  opt_t        sel, sel_next;
  logic [31:0] blk, blk_next;
  logic [31:0] tmo, tmo_next;
  logic [31:0] tsz, tsz_next;
  logic [7:0]  pair_cnt, pair_cnt_next;

  logic [7:0]  b;
  logic [7:0]  lc;
  logic        is_zero, is_ws, is_digit, is_sign;
  logic        in_value, empty_end;
  logic [2:0]  mismatch;
  opt_t        name_sel;
  logic [35:0] acc_mul;
  logic [31:0] acc_step;
  logic        commit;
  logic [31:0] src_acc;
  logic        src_neg;
  logic [31:0] commit_val;

  assign b        = beat.data_byte;
  assign lc       = (b inside {[8'h41:8'h5A]}) ? b + 8'd32 : b;
  assign is_zero  = (b == 8'h00);
  assign is_ws    = b inside {8'h20, [8'h09:8'h0D]};
  assign is_digit = b inside {[8'h30:8'h39]};
  assign is_sign  = (b == 8'h2D) || (b == 8'h2B);
  assign in_value = (phase == PH_VLEAD) || (phase == PH_VDIGITS);

  // NUL at the start of a name segment closes the packet
  assign empty_end = !beat.first_byte && (phase == PH_NAME) && is_zero && seg_empty;
  assign emit = (beat.first_byte && beat.last_byte) ||
                (!beat.first_byte && (phase != PH_IDLE) && (beat.last_byte || empty_end));

  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      mismatch[k] = (pos < KW_LEN[k]) && (lc != kw_char(2'(k), pos));
    end
  end

  // first keyword in list order wins
  always_comb begin
    name_sel = OPT_NONE;
    if (flags[2] && pos >= KW_LEN[2]) name_sel = OPT_TSIZE;
    if (flags[1] && pos >= KW_LEN[1]) name_sel = OPT_TIMEOUT;
    if (flags[0] && pos >= KW_LEN[0]) name_sel = OPT_BLKSIZE;
  end

  // acc <= 2^31, so acc*10 + 9 fits in 36 bits
  assign acc_mul  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'h0, b[3:0] - 4'h0};
  assign acc_step = (acc_mul > {4'h0, MAG_LIMIT}) ? MAG_LIMIT : acc_mul[31:0];

  // next phase
  always_comb begin
    phase_next = phase;
    if (beat.first_byte) begin
      phase_next = PH_OPCODE;
    end else begin
      case (phase)
        PH_OPCODE: phase_next = PH_NAME;
        PH_NAME: begin
          if (is_zero) phase_next = PH_VLEAD;
        end
        PH_VLEAD: begin
          if (is_zero) phase_next = PH_NAME;
          else if (!is_ws) phase_next = PH_VDIGITS;
        end
        PH_VDIGITS: begin
          if (is_zero) phase_next = PH_NAME;
        end
        default: phase_next = phase;
      endcase
    end
    if (emit) phase_next = PH_IDLE;
  end

  // datapath
  always_comb begin
    flags_next     = flags;
    pos_next       = pos;
    seg_empty_next = seg_empty;
    acc_next       = acc;
    neg_next       = neg;
    done_next      = done;
    sel_next       = sel;
    pair_cnt_next  = pair_cnt;
    if (beat.first_byte) begin
      pair_cnt_next  = 8'h00;
      flags_next     = 3'b111;
      pos_next       = 3'd0;
      seg_empty_next = 1'b1;
      sel_next       = OPT_NONE;
    end else begin
      case (phase)
        PH_OPCODE: begin
          flags_next     = 3'b111;
          pos_next       = 3'd0;
          seg_empty_next = 1'b1;
          sel_next       = OPT_NONE;
        end
        PH_NAME: begin
          if (is_zero) begin
            if (!seg_empty) begin
              seg_empty_next = 1'b1;
              acc_next       = 32'h0;
              neg_next       = 1'b0;
              done_next      = 1'b0;
              sel_next       = name_sel;
            end
          end else begin
            if (seg_empty) begin
              pair_cnt_next  = pair_cnt + 8'd1;
              seg_empty_next = 1'b0;
            end
            if (pos != 3'd7) begin
              flags_next = flags & ~mismatch;
              pos_next   = pos + 3'd1;
            end
          end
        end
        PH_VLEAD, PH_VDIGITS: begin
          if (is_zero) begin
            flags_next     = 3'b111;
            pos_next       = 3'd0;
            seg_empty_next = 1'b1;
            sel_next       = OPT_NONE;
          end else begin
            seg_empty_next = 1'b0;
            if (phase == PH_VLEAD && b == 8'h2D) neg_next = 1'b1;
            if ((phase == PH_VDIGITS || !(is_ws || is_sign)) && !done) begin
              if (!is_digit) done_next = 1'b1;
              else           acc_next  = acc_step;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // NUL commits the value so far; a last byte inside a non-empty value commits it too
  assign commit     = !beat.first_byte && in_value && (is_zero || beat.last_byte);
  assign src_acc    = is_zero ? acc : acc_next;
  assign src_neg    = is_zero ? neg : neg_next;
  assign commit_val = src_neg ? 32'h0 - src_acc : (src_acc[31] ? POS_MAX : src_acc);

  always_comb begin
    blk_next = blk;
    tmo_next = tmo;
    tsz_next = tsz;
    if (commit) begin
      case (sel)
        OPT_BLKSIZE: blk_next = commit_val;
        OPT_TIMEOUT: tmo_next = commit_val;
        OPT_TSIZE:   tsz_next = commit_val;
        default: ;
      endcase
    end
  end

  assign result.block_size    = blk_next;
  assign result.timeout_value = tmo_next;
  assign result.transfer_size = tsz_next;
  assign result.option_count  = pair_cnt_next;
  assign result.end_kind      = empty_end ? END_EMPTY_SEG : END_LAST_BYTE;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      flags     <= 3'b111;
      pos       <= 3'd0;
      seg_empty <= 1'b1;
      acc       <= 32'h0;
      neg       <= 1'b0;
      done      <= 1'b0;
      sel       <= OPT_NONE;
      blk       <= 32'h0;
      tmo       <= 32'h0;
      tsz       <= 32'h0;
      pair_cnt  <= 8'h00;
    end else if (step) begin
      phase     <= phase_next;
      flags     <= flags_next;
      pos       <= pos_next;
      seg_empty <= seg_empty_next;
      acc       <= acc_next;
      neg       <= neg_next;
      done      <= done_next;
      sel       <= sel_next;
      blk       <= blk_next;
      tmo       <= tmo_next;
      tsz       <= tsz_next;
      pair_cnt  <= pair_cnt_next;
    end
  end

endmodule

/* hdl/tftp_option_ack_parser.sv */
// Top level: input register, parser core and result register.
//
//  channel   valid          stall          payload
//  bytes     byte_valid     byte_stall     byte_data   (in_beat_t)
//  results   result_valid   result_stall   result_data (out_beat_t)
//
// One byte per cycle while result_stall is low; a byte beat passes the input register,
// then the combinational core, and its result is captured in the result register.
// Reset (rst, synchronous) returns the parser to idle and clears the stored options.
// A stalled result holds the core and the input register; one more byte beat is
// still taken into the input register while the result waits.
module tftp_option_ack_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     byte_valid,
  output logic                     byte_stall,
  input  tftp_oack_pkg::in_beat_t  byte_data,
  output logic                     result_valid,
  input  logic                     result_stall,
  output tftp_oack_pkg::out_beat_t result_data
);
  import tftp_oack_pkg::*;

  `include "tftp_option_ack_parser_defines.svh"

  in_beat_t  in_q;
  logic      in_q_valid;
  logic      advance;
  logic      in_fire;
  logic      step;
  logic      emit;
  out_beat_t core_result;

  assign advance    = !result_valid || !result_stall;
  assign byte_stall = in_q_valid && !advance;
  assign in_fire    = byte_valid && !byte_stall;
  assign step       = in_q_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_fire) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_q <= byte_data;
    end
  end

  tftp_oack_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .beat   (in_q),
    .emit   (emit),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      result_data <= core_result;
    end
  end

  `TOAP_ASSERT_IMPL(a_stall_only_when_full, byte_stall, in_q_valid, "stall with empty input register")
  `TOAP_ASSERT_NEXT(a_one_byte_packet, step && in_q.first_byte && in_q.last_byte, result_valid && result_data.end_kind, "one-byte packet gave no result")
  `TOAP_ASSERT_IMPL(a_result_has_source, $rose(result_valid), $past(in_q_valid), "result without a byte beat")

endmodule

/* tb/tftp_oack_checker.sv */
// Scoreboard for the OACK option parser: predicts results from accepted bytes and checks them.
`timescale 1ns / 1ps
module tftp_oack_checker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     byte_valid,
  input  logic                     byte_stall,
  input  tftp_oack_pkg::in_beat_t  byte_data,
  input  logic                     result_valid,
  input  logic                     result_stall,
  input  tftp_oack_pkg::out_beat_t result_data,
  output int                       error_count,
  output int                       pending_count,
  output int                       result_count
);
  import tftp_oack_pkg::*;

  localparam longint unsigned SAT_MAG = 64'h8000_0000;
  localparam logic [31:0]     INT_MAX = 32'h7FFF_FFFF;

  // predicted parser state
  phase_t          phase;
  logic [2:0]      key_alive;
  int unsigned     name_len;
  bit              seg_empty;
  longint unsigned magnitude;
  bit              minus;
  bit              digits_over;
  opt_t            picked;
  logic [31:0]     opt_blksize;
  logic [31:0]     opt_timeout;
  logic [31:0]     opt_tsize;
  logic [7:0]      pairs_read;

  out_beat_t expected_acks [$];
  out_beat_t want;
  int errors = 0;
  int waiting = 0;
  int checked = 0;

  assign error_count   = errors;
  assign pending_count = waiting;
  assign result_count  = checked;

  function automatic string keyword(input int k);
    case (k)
      0:       return "blksize";
      1:       return "timeout";
      default: return "tsize";
    endcase
  endfunction

  task automatic clear_state();
    phase       = PH_IDLE;
    key_alive   = 3'b111;
    name_len    = 0;
    seg_empty   = 1'b1;
    magnitude   = 0;
    minus       = 1'b0;
    digits_over = 1'b0;
    picked      = OPT_NONE;
    opt_blksize = '0;
    opt_timeout = '0;
    opt_tsize   = '0;
    pairs_read  = '0;
    waiting     = 0;
    expected_acks.delete();
  endtask

  task automatic open_name();
    phase     = PH_NAME;
    key_alive = 3'b111;
    name_len  = 0;
    seg_empty = 1'b1;
    picked    = OPT_NONE;
  endtask

  task automatic store_value();
    logic [31:0] v;
    if (minus) v = 32'd0 - magnitude[31:0];
    else if (magnitude > INT_MAX) v = INT_MAX;
    else v = magnitude[31:0];
    case (picked)
      OPT_BLKSIZE: opt_blksize = v;
      OPT_TIMEOUT: opt_timeout = v;
      OPT_TSIZE:   opt_tsize = v;
      default:     ;
    endcase
  endtask

  task automatic finish_packet(input logic kind);
    out_beat_t e;
    e.block_size    = opt_blksize;
    e.timeout_value = opt_timeout;
    e.transfer_size = opt_tsize;
    e.option_count  = pairs_read;
    e.end_kind      = kind;
    expected_acks.push_back(e);
    waiting++;
    phase = PH_IDLE;
  endtask

  task automatic track_byte(input in_beat_t b);
    logic [7:0] c;
    logic [7:0] lc;
    string      kw;
    opt_t       hit;
    bit         sign_char;
    c = b.data_byte;
    if (b.first_byte) begin
      phase      = PH_OPCODE;
      pairs_read = '0;
      key_alive  = 3'b111;
      name_len   = 0;
      seg_empty  = 1'b1;
      picked     = OPT_NONE;
      if (b.last_byte) finish_packet(END_LAST_BYTE);
      return;
    end
    case (phase)
      PH_IDLE: return;
      PH_OPCODE: open_name();
      PH_NAME: begin
        if (c == 8'h00) begin
          if (seg_empty) begin
            finish_packet(END_EMPTY_SEG);
            return;
          end
          // earliest keyword in table order wins, so scan downward
          hit = OPT_NONE;
          for (int k = 2; k >= 0; k--) begin
            kw = keyword(k);
            if (key_alive[k] && name_len >= kw.len()) hit = opt_t'(k + 1);
          end
          phase       = PH_VLEAD;
          seg_empty   = 1'b1;
          magnitude   = 0;
          minus       = 1'b0;
          digits_over = 1'b0;
          picked      = hit;
        end else begin
          lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
          if (seg_empty) begin
            pairs_read++;
            seg_empty = 1'b0;
          end
          if (name_len < 7) begin
            for (int k = 0; k < 3; k++) begin
              kw = keyword(k);
              if (name_len < kw.len() && lc != kw[name_len]) key_alive[k] = 1'b0;
            end
            name_len++;
          end
        end
      end
      default: begin
        if (c == 8'h00) begin
          store_value();
          open_name();
        end else begin
          seg_empty = 1'b0;
          if (!(phase == PH_VLEAD && (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)))) begin
            sign_char = 1'b0;
            if (phase == PH_VLEAD) begin
              phase = PH_VDIGITS;
              if (c == "-") begin
                minus     = 1'b1;
                sign_char = 1'b1;
              end else if (c == "+") begin
                sign_char = 1'b1;
              end
            end
            if (!sign_char && !digits_over) begin
              if (c < "0" || c > "9") begin
                digits_over = 1'b1;
              end else begin
                magnitude = magnitude * 10 + (c - "0");
                if (magnitude > SAT_MAG) magnitude = SAT_MAG;
              end
            end
          end
        end
      end
    endcase
    if (b.last_byte) begin
      // a partly read value still lands when the packet is cut short
      if ((phase == PH_VLEAD || phase == PH_VDIGITS) && !seg_empty) store_value();
      finish_packet(END_LAST_BYTE);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (byte_valid && !byte_stall) track_byte(byte_data);
      if (result_valid && !result_stall) begin
        if (expected_acks.size() == 0) begin
          $error("result beat with no packet end pending (option_count %0d)",
                 result_data.option_count);
          errors++;
        end else begin
          want = expected_acks.pop_front();
          waiting--;
          checked++;
          if (result_data.block_size !== want.block_size) begin
            $error("block_size: expected %0d, got %0d", want.block_size,
                   result_data.block_size);
            errors++;
          end
          if (result_data.timeout_value !== want.timeout_value) begin
            $error("timeout_value: expected %0d, got %0d", want.timeout_value,
                   result_data.timeout_value);
            errors++;
          end
          if (result_data.transfer_size !== want.transfer_size) begin
            $error("transfer_size: expected %0d, got %0d", want.transfer_size,
                   result_data.transfer_size);
            errors++;
          end
          if (result_data.option_count !== want.option_count) begin
            $error("option_count: expected %0d, got %0d", want.option_count,
                   result_data.option_count);
            errors++;
          end
          if (result_data.end_kind !== want.end_kind) begin
            $error("end_kind: expected %0d, got %0d", want.end_kind, result_data.end_kind);
            errors++;
          end
        end
      end
    end
  end

endmodule

/* tb/tb_tftp_option_ack_parser.sv */
// Testbench top for the OACK option parser: clock, reset, byte stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_tftp_option_ack_parser;
  import tftp_oack_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  in_beat_t  byte_data = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_beat_t result_data;

  int fail_count;
  int pending;
  int results_done;

  logic [7:0] pkt [$];
  string      key_list [3] = '{"blksize", "timeout", "tsize"};
  int         bytes_sent = 0;
  int         packets_sent = 0;
  int         gap_odds = 0;   // one gap per gap_odds bytes on average, 0 = no gaps
  bit         stall_enable = 1'b0;

  tftp_option_ack_parser dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  tftp_oack_checker scoreboard (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .byte_data     (byte_data),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result_data   (result_data),
    .error_count   (fail_count),
    .pending_count (pending),
    .result_count  (results_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure in bursts
  initial begin
    forever begin
      @(posedge clk);
      if (stall_enable && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  task automatic put_byte(input logic [7:0] d, input logic f, input logic l);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    byte_data  <= {d, f, l};
    byte_valid <= 1'b1;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  // segment text followed by its NUL
  task automatic seg(input string s);
    for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
    pkt.push_back(8'h00);
  endtask

  task automatic send_pkt(input bit mark_last);
    for (int i = 0; i < pkt.size(); i++)
      put_byte(pkt[i], i == 0, mark_last && i == pkt.size() - 1);
    bytes_sent += pkt.size();
    packets_sent++;
    pkt.delete();
  endtask

  // hold the sender until every packet end seen so far has been answered
  task automatic drain();
    byte_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic add_name();
    string      kw;
    logic [7:0] ch;
    int         pos;
    kw = key_list[$urandom_range(0, 2)];
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        for (int i = 0; i < kw.len(); i++) begin
          ch = kw[i];
          if ($urandom_range(0, 1)) ch = ch - 8'd32;
          pkt.push_back(ch);
        end
        if ($urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(1, 255)));
      end
      6: begin
        pos = $urandom_range(1, kw.len() - 1);
        for (int i = 0; i < pos; i++) pkt.push_back(kw[i]);
      end
      7: begin
        pos = $urandom_range(0, kw.len() - 1);
        for (int i = 0; i < kw.len(); i++)
          pkt.push_back(i == pos ? 8'($urandom_range(1, 255)) : kw[i]);
      end
      default: repeat ($urandom_range(1, 9)) pkt.push_back(8'($urandom_range(1, 255)));
    endcase
    pkt.push_back(8'h00);
  endtask

  task automatic add_value();
    int r;
    repeat ($urandom_range(0, 2)) begin
      r = $urandom_range(0, 5);
      pkt.push_back(r == 0 ? 8'h20 : 8'(8 + r));
    end
    r = $urandom_range(0, 5);
    if (r == 0) pkt.push_back("-");
    else if (r == 1) pkt.push_back("+");
    r = $urandom_range(0, 9);
    repeat (r == 0 ? 0 : (r < 3 ? $urandom_range(9, 12) : $urandom_range(1, 5)))
      pkt.push_back(8'("0" + $urandom_range(0, 9)));
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(1, 255)));
    pkt.push_back(8'h00);
  endtask

  initial begin
    int style;
    int cut;
    gap_odds = 6;
    stall_enable = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // bytes ahead of any packet start are ignored
    put_byte(8'hFF, 1'b0, 1'b0);
    put_byte(8'h00, 1'b0, 1'b1);
    // one-byte packet: first and last on the same beat
    pkt.push_back(8'h00);
    send_pkt(1'b1);
    // whitespace, signs, case, empty value, unknown name, empty segment on last byte
    pkt = '{8'h00, 8'h06};
    seg("BlkSize");
    seg("\040\011\012\013\014\015+2147483647");
    seg("TIMEOUT");
    seg("");
    seg("tSizeX");
    seg("-2147483648");
    seg("bogus");
    seg("77");
    seg("");
    send_pkt(1'b1);
    // abandoned by the next packet start
    pkt = '{8'h00, 8'h06};
    seg("timeout");
    seg("42");
    send_pkt(1'b0);
    // positive saturation, cut inside a value after a non-digit
    pkt = '{8'hFF, 8'h00};
    seg("blksize");
    seg("2147483648");
    seg("timeout");
    seg("-12x3");
    void'(pkt.pop_back());
    send_pkt(1'b1);
    // cut inside a name, then cut in the opcode
    pkt = '{8'h00, 8'h06, "t", "s", "i"};
    send_pkt(1'b1);
    pkt = '{8'h00, 8'h06};
    send_pkt(1'b1);
    drain();

    while (bytes_sent < 2000) begin
      if (bytes_sent >= 1700) begin
        gap_odds = 0;
        stall_enable = 1'b0;
      end else begin
        gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 12);
        stall_enable = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 4) == 0) begin
        pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(8'($urandom_range(0, 255)));
      end else begin
        pkt = '{8'h00, 8'h06};
      end
      if (packets_sent == 20) begin
        // enough pairs to wrap the 8-bit pair count
        repeat (262) pkt = {pkt, 8'h61, 8'h00, 8'h00};
        pkt.push_back(8'h00);
        send_pkt(1'b1);
      end else begin
        repeat ($urandom_range(0, 4)) begin
          add_name();
          add_value();
        end
        style = $urandom_range(0, 19);
        if (style < 7) begin
          pkt.push_back(8'h00);
          send_pkt(1'b1);
        end else if (style < 10) begin
          pkt.push_back(8'h00);
          repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(0, 255)));
          send_pkt(1'($urandom_range(0, 1)));
        end else if (style < 17) begin
          cut = $urandom_range(1, pkt.size());
          while (pkt.size() > cut) void'(pkt.pop_back());
          send_pkt(1'b1);
        end else begin
          send_pkt(1'b0);
        end
      end
      // stray bytes between packets
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3))
          put_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      if (packets_sent % 16 == 0 && bytes_sent < 1700) drain();
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Covered %0d packet bytes in %0d packets: directed corner cases, random options,",
             bytes_sent, packets_sent);
    $display("cut and abandoned packets, stray bytes and a wrapping pair count; %0d results.",
             results_done);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5_000_000;
    $error("timeout: %0d results still outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/tftp_oack_pkg.sv
hdl/tftp_oack_core.sv
hdl/tftp_option_ack_parser.sv
tb/tftp_oack_checker.sv
tb/tb_tftp_option_ack_parser.sv
